>>> hw/rtl/eulrot_pkg.sv
// shared types, constants and helpers of the euler three-axis vector rotation
package eulrot_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned IN_W           = 18;
  localparam int unsigned COMP_W         = 22;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned PROD_W         = COMP_W + COEF_W;
  localparam int unsigned DATA_W         = 56;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30   = 64'd1 << 29;
  localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;

  localparam logic signed [IN_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [IN_W-1:0] OUT_MIN = -18'sd131072;

  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_NONE = 2'd3
  } axis_e;

  typedef enum logic [IDX_W-1:0] {
    REG_FIRST_ANGLE  = 3'd0,
    REG_SECOND_ANGLE = 3'd1,
    REG_THIRD_ANGLE  = 3'd2,
    REG_FIRST_AXIS   = 3'd3,
    REG_SECOND_AXIS  = 3'd4,
    REG_THIRD_AXIS   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_LOAD,
    SC_X,
    SC_X2MUL,
    SC_X2,
    SC_HMUL,
    SC_DIVINIT,
    SC_DIV,
    SC_TUPD,
    SC_SMUL,
    SC_S,
    SC_CMUL,
    SC_C
  } sc_state_e;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] sn;
    logic signed [COEF_W-1:0] cs;
  } coef_t;

  // taylor term divisor: sine (2n)(2n+1), cosine (2n-1)(2n)
  function automatic logic [7:0] term_div(input logic is_cos, input logic [3:0] n);
    logic [7:0] e;
    e = {3'b000, n, 1'b0};
    return is_cos ? 8'((e - 8'd1) * e) : 8'(e * (e + 8'd1));
  endfunction

  // low word of ceil(2^sh / d), the top bit 2^32 being implied
  function automatic logic [31:0] recip_of(input int unsigned d, input int unsigned sh);
    return 32'(((64'd1 << sh) + 64'(d) - 64'd1) / 64'(d));
  endfunction

  // reciprocal of a taylor divisor, exact floor for any 32-bit dividend
  function automatic logic [31:0] recip_lo(input logic [7:0] d);
    logic [31:0] lo;
    unique case (d)
      8'd6:    lo = recip_of(6, 35);
      8'd12:   lo = recip_of(12, 36);
      8'd20:   lo = recip_of(20, 37);
      8'd30:   lo = recip_of(30, 37);
      8'd42:   lo = recip_of(42, 38);
      8'd56:   lo = recip_of(56, 38);
      8'd72:   lo = recip_of(72, 39);
      8'd90:   lo = recip_of(90, 39);
      8'd110:  lo = recip_of(110, 39);
      8'd132:  lo = recip_of(132, 40);
      8'd156:  lo = recip_of(156, 40);
      8'd182:  lo = recip_of(182, 40);
      8'd210:  lo = recip_of(210, 40);
      8'd240:  lo = recip_of(240, 40);
      default: lo = '0;
    endcase
    return lo;
  endfunction

  // shift matching recip_lo: 32 plus the bits of the divisor
  function automatic logic [5:0] recip_sh(input logic [7:0] d);
    logic [5:0] sh;
    unique case (d)
      8'd6:                   sh = 6'd35;
      8'd12:                  sh = 6'd36;
      8'd20, 8'd30:           sh = 6'd37;
      8'd42, 8'd56:           sh = 6'd38;
      8'd72, 8'd90, 8'd110:   sh = 6'd39;
      default:                sh = 6'd40;
    endcase
    return sh;
  endfunction

endpackage

>>> hw/rtl/eulrot_sincos.sv
// sequential sine and cosine unit for the three rotation angles
module eulrot_sincos #(
  parameter int unsigned ANGLE_BITS = eulrot_pkg::ANGLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ANGLE_BITS-1:0]  angle_i [3],
  output logic                   busy_o,
  output eulrot_pkg::coef_t      coef_o [3]
);

  eulrot_pkg::sc_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] x_q, x_d, x2_q, x2_d, div_q, div_d, mul_a, mul_b;
  logic [30:0] t_q, t_d, s_q, s_d;
  logic [3:0]  n_q, n_d;
  logic        cos_q, cos_d;
  logic [7:0]  k_q, k_d;
  logic [63:0] prod_q, rnd;
  logic [31:0] phase, m, quo;
  logic [64:0] qsum;
  logic [30:0] h, c_val;
  logic signed [31:0] sp, cp;
  eulrot_pkg::coef_t coef_q [3];

  assign phase  = 32'(angle_i[idx_q]) << (32 - ANGLE_BITS);
  assign rnd    = prod_q + eulrot_pkg::HALF_Q30;
  assign m      = prod_q[61:30];
  // quotient by reciprocal: dividend times (2^32 + low word), then shifted
  assign qsum   = {1'b0, prod_q} + {1'b0, div_q, 32'd0};
  assign quo    = 32'(qsum >> eulrot_pkg::recip_sh(k_q));
  assign h      = m[31:1];
  assign c_val  = (h >= 31'(eulrot_pkg::ONE_Q30)) ? 31'd0 : 31'(eulrot_pkg::ONE_Q30) - h;
  assign sp     = 32'(s_q);
  assign cp     = 32'(c_val);
  assign busy_o = state_q != eulrot_pkg::SC_IDLE;
  assign coef_o = coef_q;

  always_comb begin
    mul_a = x2_q;
    mul_b = 32'(t_q);
    unique case (state_q)
      eulrot_pkg::SC_LOAD: begin
        mul_a = {2'b00, phase[29:0]};
        mul_b = eulrot_pkg::HALFPI_Q30;
      end
      eulrot_pkg::SC_X2MUL: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      eulrot_pkg::SC_DIV: begin
        mul_a = div_q;
        mul_b = eulrot_pkg::recip_lo(k_q);
      end
      eulrot_pkg::SC_SMUL: begin
        mul_a = x_q;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eulrot_pkg::SC_IDLE:    if (start_i) state_d = eulrot_pkg::SC_LOAD;
      eulrot_pkg::SC_LOAD:    state_d = eulrot_pkg::SC_X;
      eulrot_pkg::SC_X:       state_d = eulrot_pkg::SC_X2MUL;
      eulrot_pkg::SC_X2MUL:   state_d = eulrot_pkg::SC_X2;
      eulrot_pkg::SC_X2:      state_d = eulrot_pkg::SC_HMUL;
      eulrot_pkg::SC_HMUL:    state_d = eulrot_pkg::SC_DIVINIT;
      eulrot_pkg::SC_DIVINIT: state_d = eulrot_pkg::SC_DIV;
      eulrot_pkg::SC_DIV:     state_d = eulrot_pkg::SC_TUPD;
      eulrot_pkg::SC_TUPD: begin
        if (!cos_q && n_q == 4'd1) state_d = eulrot_pkg::SC_SMUL;
        else if (cos_q && n_q == 4'd2) state_d = eulrot_pkg::SC_CMUL;
        else state_d = eulrot_pkg::SC_HMUL;
      end
      eulrot_pkg::SC_SMUL:    state_d = eulrot_pkg::SC_S;
      eulrot_pkg::SC_S:       state_d = eulrot_pkg::SC_HMUL;
      eulrot_pkg::SC_CMUL:    state_d = eulrot_pkg::SC_C;
      eulrot_pkg::SC_C:       state_d = (idx_q == 2'd2) ? eulrot_pkg::SC_IDLE
                                                        : eulrot_pkg::SC_LOAD;
      default:                state_d = eulrot_pkg::SC_IDLE;
    endcase
    if (start_i) state_d = eulrot_pkg::SC_LOAD;
  end

  // datapath
  always_comb begin
    idx_d = idx_q;
    x_d   = x_q;
    x2_d  = x2_q;
    t_d   = t_q;
    s_d   = s_q;
    n_d   = n_q;
    cos_d = cos_q;
    k_d   = k_q;
    div_d = div_q;
    unique case (state_q)
      eulrot_pkg::SC_X:  x_d = rnd[61:30];
      eulrot_pkg::SC_X2: begin
        x2_d  = rnd[61:30];
        t_d   = 31'(eulrot_pkg::ONE_Q30);
        n_d   = 4'd7;
        cos_d = 1'b0;
      end
      eulrot_pkg::SC_DIVINIT: begin
        div_d = m;
        k_d   = eulrot_pkg::term_div(cos_q, n_q);
      end
      eulrot_pkg::SC_TUPD: begin
        t_d = 31'(eulrot_pkg::ONE_Q30 - 64'(quo));
        n_d = n_q - 4'd1;
      end
      eulrot_pkg::SC_S: begin
        s_d   = (m > 32'(eulrot_pkg::ONE_Q30)) ? 31'(eulrot_pkg::ONE_Q30) : m[30:0];
        t_d   = 31'(eulrot_pkg::ONE_Q30);
        n_d   = 4'd8;
        cos_d = 1'b1;
      end
      eulrot_pkg::SC_C: idx_d = idx_q + 2'd1;
      default: ;
    endcase
    if (start_i) idx_d = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eulrot_pkg::SC_IDLE;
      idx_q   <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        coef_q[i].sn <= '0;
        coef_q[i].cs <= 32'(eulrot_pkg::ONE_Q30);
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (state_q == eulrot_pkg::SC_C && !start_i) begin
        unique case (phase[31:30])
          2'd0: begin coef_q[idx_q].sn <= sp;  coef_q[idx_q].cs <= cp;  end
          2'd1: begin coef_q[idx_q].sn <= cp;  coef_q[idx_q].cs <= -sp; end
          2'd2: begin coef_q[idx_q].sn <= -sp; coef_q[idx_q].cs <= -cp; end
          default: begin coef_q[idx_q].sn <= -cp; coef_q[idx_q].cs <= sp; end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    x_q    <= x_d;
    x2_q   <= x2_d;
    t_q    <= t_d;
    s_q    <= s_d;
    n_q    <= n_d;
    cos_q  <= cos_d;
    k_q    <= k_d;
    div_q  <= div_d;
  end

endmodule

>>> hw/rtl/eulrot_stage.sv
// one plane rotation: product stage then sum and rounding stage
module eulrot_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  eulrot_pkg::vec_t    vec_i,
  input  eulrot_pkg::coef_t   coef_i,
  input  eulrot_pkg::axis_e   axis_i,
  output logic                valid_o,
  output eulrot_pkg::vec_t    vec_o
);

  localparam int unsigned PW = eulrot_pkg::PROD_W;

  logic signed [31:0] sn, cs;
  eulrot_pkg::comp_t  a, b, na, nb;
  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [PW:0]   sum_a, sum_b;
  eulrot_pkg::vec_t   vec_a_q, vec_b_q, vec_b_d;
  eulrot_pkg::axis_e  axis_a_q;
  logic               valid_a_q, valid_b_q;

  always_comb begin
    sn = coef_i.sn;
    cs = coef_i.cs;
    a  = vec_i.x;
    b  = vec_i.y;
    unique case (axis_i)
      eulrot_pkg::AX_X: begin a = vec_i.y; b = vec_i.z; end
      eulrot_pkg::AX_Y: begin a = vec_i.z; b = vec_i.x; end
      eulrot_pkg::AX_Z: ;
      eulrot_pkg::AX_NONE: begin
        sn = '0;
        cs = 32'(eulrot_pkg::ONE_Q30);
      end
      default: ;
    endcase
  end

  assign sum_a = (PW+1)'(ca_q) - (PW+1)'(sb_q) + (PW+1)'(eulrot_pkg::HALF_Q30);
  assign sum_b = (PW+1)'(sa_q) + (PW+1)'(cb_q) + (PW+1)'(eulrot_pkg::HALF_Q30);
  assign na    = sum_a[51:30];
  assign nb    = sum_b[51:30];

  always_comb begin
    vec_b_d = vec_a_q;
    unique case (axis_a_q)
      eulrot_pkg::AX_X: begin vec_b_d.y = na; vec_b_d.z = nb; end
      eulrot_pkg::AX_Y: begin vec_b_d.z = na; vec_b_d.x = nb; end
      default:          begin vec_b_d.x = na; vec_b_d.y = nb; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q     <= PW'(cs) * PW'(a);
      sb_q     <= PW'(sn) * PW'(b);
      sa_q     <= PW'(sn) * PW'(a);
      cb_q     <= PW'(cs) * PW'(b);
      vec_a_q  <= vec_i;
      axis_a_q <= axis_i;
      vec_b_q  <= vec_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign vec_o   = vec_b_q;

endmodule

>>> hw/rtl/euler_three_axis_vector_rotate.sv
// top level of the euler three-axis vector rotation
// one word per cycle while the output is not stalled and the sine/cosine unit is idle
// three rotation stages of two registers each, then a saturating output register
// after an angle write the sine/cosine unit recomputes all three angles, input stalled
// reset: angles 0, axes z, x, z, pipeline empty, no recompute needed
module euler_three_axis_vector_rotate #(
  parameter int unsigned ANGLE_BITS = eulrot_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [eulrot_pkg::DATA_W-1:0]     s_axis_tdata,  // in_x, in_y, in_z, pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [eulrot_pkg::DATA_W-1:0]     m_axis_tdata,  // rotated_x, rotated_y, rotated_z, pad
  input  logic                              cfg_we_i,
  input  logic [eulrot_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [eulrot_pkg::CFG_W-1:0]      cfg_wdata_i
);

  logic [ANGLE_BITS-1:0] angle_q [3];
  eulrot_pkg::axis_e     axis_q [3];
  eulrot_pkg::coef_t     coef [3];
  eulrot_pkg::vec_t      vec [4];
  logic                  vld [4];
  logic                  busy, en, start, out_valid_q;
  logic [eulrot_pkg::DATA_W-1:0] out_data_q;

  function automatic logic [eulrot_pkg::IN_W-1:0] sat(input eulrot_pkg::comp_t v);
    if (v > eulrot_pkg::COMP_W'(eulrot_pkg::OUT_MAX)) return eulrot_pkg::OUT_MAX;
    if (v < eulrot_pkg::COMP_W'(eulrot_pkg::OUT_MIN)) return eulrot_pkg::OUT_MIN;
    return v[eulrot_pkg::IN_W-1:0];
  endfunction

  assign start = cfg_we_i && (cfg_idx_i == eulrot_pkg::REG_FIRST_ANGLE
                           || cfg_idx_i == eulrot_pkg::REG_SECOND_ANGLE
                           || cfg_idx_i == eulrot_pkg::REG_THIRD_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q[0] <= '0;
      angle_q[1] <= '0;
      angle_q[2] <= '0;
      axis_q[0]  <= eulrot_pkg::AX_Z;
      axis_q[1]  <= eulrot_pkg::AX_X;
      axis_q[2]  <= eulrot_pkg::AX_Z;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eulrot_pkg::REG_FIRST_ANGLE:  angle_q[0] <= ANGLE_BITS'(cfg_wdata_i);
        eulrot_pkg::REG_SECOND_ANGLE: angle_q[1] <= ANGLE_BITS'(cfg_wdata_i);
        eulrot_pkg::REG_THIRD_ANGLE:  angle_q[2] <= ANGLE_BITS'(cfg_wdata_i);
        eulrot_pkg::REG_FIRST_AXIS:   axis_q[0]  <= eulrot_pkg::axis_e'(cfg_wdata_i[1:0]);
        eulrot_pkg::REG_SECOND_AXIS:  axis_q[1]  <= eulrot_pkg::axis_e'(cfg_wdata_i[1:0]);
        eulrot_pkg::REG_THIRD_AXIS:   axis_q[2]  <= eulrot_pkg::axis_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  eulrot_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .angle_i (angle_q),
    .busy_o  (busy),
    .coef_o  (coef)
  );

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign vld[0]        = s_axis_tvalid && s_axis_tready;
  assign vec[0].x      = eulrot_pkg::COMP_W'($signed(s_axis_tdata[17:0]));
  assign vec[0].y      = eulrot_pkg::COMP_W'($signed(s_axis_tdata[35:18]));
  assign vec[0].z      = eulrot_pkg::COMP_W'($signed(s_axis_tdata[53:36]));

  for (genvar g = 0; g < 3; g++) begin : g_rot
    eulrot_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .vec_i   (vec[g]),
      .coef_i  (coef[g]),
      .axis_i  (axis_q[g]),
      .valid_o (vld[g+1]),
      .vec_o   (vec[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {2'b00, sat(vec[3].z), sat(vec[3].y), sat(vec[3].x)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_busy_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input taken while coefficients are being computed");

  a_output_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the pipeline is stalled");

  a_angle_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("angle write did not start a recompute");

endmodule
